### src/ecrm_pkg.sv
// ----------------------------------------------------------------------------
// ecrm_pkg: shared types and constants for the equity curve risk metrics block
// Divider request word, register indexes and fixed-point constants.
// ----------------------------------------------------------------------------
package ecrm_pkg;

    localparam int EQ_W     = 48;
    localparam int FACTOR_W = 32;
    localparam int DD_W     = 25;
    localparam int OUT_W    = 32;

    // register indexes on the config port
    localparam logic CFG_CAPITAL = 1'b0;
    localparam logic CFG_FACTOR  = 1'b1;

    localparam logic [63:0] ONE_Q24  = 64'h0000_0000_0100_0000;
    // ratio cap so that ratio - 1.0 stays within a signed 32-bit word
    localparam logic [63:0] RATIO_CAP = 64'h0000_0000_8100_0000 - 64'd1;
    localparam logic [63:0] POS_CAP   = 64'h0000_0000_7FFF_FFFF;
    localparam logic [63:0] NEG_CAP   = 64'h0000_0000_8000_0000;

    // iteration counts of the divider
    localparam logic [7:0] FRAC_ITERS = 8'd72;
    localparam logic [7:0] WIDE_ITERS = 8'd128;

    typedef struct packed {
        logic [127:0] num;    // numerator, MSB aligned
        logic [63:0]  den;
        logic [7:0]   iters;  // numerator bits consumed
        logic [63:0]  cap;    // quotient saturates here
    } div_req_t;

endpackage

### src/ecrm_div.sv
// ----------------------------------------------------------------------------
// ecrm_div: iterative restoring divider
// One quotient bit per cycle, saturating quotient, pulse on done.
// ----------------------------------------------------------------------------
module ecrm_div
    import ecrm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  div_req_t    req,
    output logic        done,
    output logic [63:0] quot
);

    logic [127:0] num_reg, num_next;
    logic [63:0]  den_reg, den_next;
    logic [63:0]  cap_reg, cap_next;
    logic [63:0]  rem_reg, rem_next;
    logic [63:0]  q_reg, q_next;
    logic [63:0]  quot_reg, quot_next;
    logic [7:0]   cnt_reg, cnt_next;
    logic         ovf_reg, ovf_next;
    logic         run_reg, run_next;
    logic         fin_reg, fin_next;
    logic         done_reg, done_next;
    logic [64:0]  shifted;
    logic         fits;

    assign shifted = {rem_reg, num_reg[127]};
    assign fits    = shifted >= {1'b0, den_reg};

    always_comb
    begin
        num_next  = num_reg;
        den_next  = den_reg;
        cap_next  = cap_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        ovf_next  = ovf_reg;
        run_next  = run_reg;
        fin_next  = 1'b0;
        done_next = 1'b0;
        if (start)
        begin
            num_next = req.num;
            den_next = req.den;
            cap_next = req.cap;
            cnt_next = req.iters;
            rem_next = '0;
            q_next   = '0;
            ovf_next = 1'b0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            num_next = {num_reg[126:0], 1'b0};
            rem_next = fits ? 64'(shifted - {1'b0, den_reg}) : shifted[63:0];
            q_next   = {q_reg[62:0], fits};
            ovf_next = ovf_reg | q_reg[63];
            cnt_next = cnt_reg - 8'd1;
            if (cnt_reg == 8'd1)
            begin
                run_next = 1'b0;
                fin_next = 1'b1;
            end
        end
        else if (fin_reg)
        begin
            quot_next = (ovf_reg || q_reg > cap_reg) ? cap_reg : q_reg;
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            fin_reg  <= fin_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        den_reg  <= den_next;
        cap_reg  <= cap_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        quot_reg <= quot_next;
        cnt_reg  <= cnt_next;
        ovf_reg  <= ovf_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

### src/ecrm_mul.sv
// ----------------------------------------------------------------------------
// ecrm_mul: 64 x 64 multiplier built on one 32 x 32 multiplier
// Four partial products, registered, then accumulated into 128 bits.
// ----------------------------------------------------------------------------
module ecrm_mul
    import ecrm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [63:0]  a,
    input  logic [63:0]  b,
    output logic         done,
    output logic [127:0] prod
);

    logic [63:0]  a_reg, a_next;
    logic [63:0]  b_reg, b_next;
    logic [127:0] acc_reg, acc_next;
    logic [63:0]  pp_reg, pp_next;
    logic [1:0]   sh_reg, sh_next;
    logic [2:0]   cnt_reg, cnt_next;
    logic         pv_reg, pv_next;
    logic         busy_reg, busy_next;
    logic         done_reg, done_next;
    logic [31:0]  a_part, b_part;
    logic [127:0] pp_aligned;

    assign a_part = cnt_reg[1] ? a_reg[63:32] : a_reg[31:0];
    assign b_part = cnt_reg[0] ? b_reg[63:32] : b_reg[31:0];

    always_comb
    begin
        case (sh_reg)
            2'd0:    pp_aligned = {64'd0, pp_reg};
            2'd1:    pp_aligned = {32'd0, pp_reg, 32'd0};
            default: pp_aligned = {pp_reg, 64'd0};
        endcase
    end

    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        pp_next   = pp_reg;
        sh_next   = sh_reg;
        cnt_next  = cnt_reg;
        pv_next   = 1'b0;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            a_next    = a;
            b_next    = b;
            acc_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (pv_reg)
                acc_next = acc_reg + pp_aligned;
            if (cnt_reg != 3'd4)
            begin
                pp_next  = a_part * b_part;
                sh_next  = 2'({1'b0, cnt_reg[1]} + {1'b0, cnt_reg[0]});
                pv_next  = 1'b1;
                cnt_next = cnt_reg + 3'd1;
            end
            else
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            pv_reg   <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            pv_reg   <= pv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
        pp_reg  <= pp_next;
        sh_reg  <= sh_next;
        cnt_reg <= cnt_next;
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

### src/ecrm_sqrt.sv
// ----------------------------------------------------------------------------
// ecrm_sqrt: digit-by-digit integer square root
// 128-bit radicand, one root bit per cycle, truncated 64-bit root.
// ----------------------------------------------------------------------------
module ecrm_sqrt
    import ecrm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [127:0] radicand,
    output logic         done,
    output logic [63:0]  root
);

    logic [127:0] rad_reg, rad_next;
    logic [65:0]  rem_reg, rem_next;
    logic [63:0]  root_reg, root_next;
    logic [6:0]   cnt_reg, cnt_next;
    logic         busy_reg, busy_next;
    logic         done_reg, done_next;
    logic [67:0]  shifted;
    logic [67:0]  trial;
    logic         fits;

    assign shifted = {rem_reg, rad_reg[127:126]};
    assign trial   = {2'b00, root_reg, 2'b01};
    assign fits    = shifted >= trial;

    always_comb
    begin
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rad_next  = {rad_reg[125:0], 2'b00};
            rem_next  = fits ? 66'(shifted - trial) : shifted[65:0];
            root_next = {root_reg[62:0], fits};
            cnt_next  = cnt_reg + 7'd1;
            if (cnt_reg == 7'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        cnt_reg  <= cnt_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

### src/equity_curve_risk_metrics.sv
// ----------------------------------------------------------------------------
// equity_curve_risk_metrics: total return, max drawdown and Sharpe ratio
// Sequencer over a shared divider, multiplier and square root unit.
// ----------------------------------------------------------------------------
//
//  channel | handshake             | word
//  --------+-----------------------+------------------------------------------
//  in      | in_valid / in_stall   | equity_value, last_sample
//  out     | out_valid / out_stall | total_ret, largest_drawdown,
//          |                       | sharpe, sharpe_valid
//  cfg     | cfg_write             | cfg_index, cfg_data
//
//  Work: an ordinary sample takes up to two 72-step divisions on the shared
//  divider plus one 64-bit multiply; a last sample adds up to one 72-step
//  and one 128-step division, three multiplies and a 64-step square root.
//  The divider works one bit per cycle.
//  Reset clears the curve state and loads the register defaults.
//  in_stall is high while a sample is being worked; the result word sits in
//  an output register, and a new sample is taken while it waits.
//
module equity_curve_risk_metrics
    import ecrm_pkg::*;
#(
    parameter longint unsigned MAX_SAMPLES          = 64'd1048576,
    parameter int              EQUITY_FRACTION_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [47:0]        equity_value,
    input  logic               last_sample,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] total_ret,
    output logic [24:0]        largest_drawdown,
    output logic signed [31:0] sharpe,
    output logic               sharpe_valid,
    input  logic               cfg_write,
    input  logic               cfg_index,
    input  logic [47:0]        cfg_data
);

    localparam int CW = $clog2(MAX_SAMPLES);
    localparam logic [CW-1:0] CNT_LIMIT = CW'(MAX_SAMPLES - 64'd1);
    localparam logic [47:0] CAPITAL_RESET = 48'(64'd1000000 << EQUITY_FRACTION_BITS);
    localparam logic [31:0] FACTOR_RESET  = 32'd6133835;

    // sequencer states
    localparam logic [4:0] ST_IDLE   = 5'd0;
    localparam logic [4:0] ST_PEAK   = 5'd1;
    localparam logic [4:0] ST_DD     = 5'd2;
    localparam logic [4:0] ST_DD_W   = 5'd3;
    localparam logic [4:0] ST_RET    = 5'd4;
    localparam logic [4:0] ST_RET_W  = 5'd5;
    localparam logic [4:0] ST_SQ     = 5'd6;
    localparam logic [4:0] ST_SQ_W   = 5'd7;
    localparam logic [4:0] ST_ADV    = 5'd8;
    localparam logic [4:0] ST_TOT    = 5'd9;
    localparam logic [4:0] ST_TOT_W  = 5'd10;
    localparam logic [4:0] ST_NQ     = 5'd11;
    localparam logic [4:0] ST_NQ_W   = 5'd12;
    localparam logic [4:0] ST_S2     = 5'd13;
    localparam logic [4:0] ST_S2_W   = 5'd14;
    localparam logic [4:0] ST_SQRT   = 5'd15;
    localparam logic [4:0] ST_SQRT_W = 5'd16;
    localparam logic [4:0] ST_NUM    = 5'd17;
    localparam logic [4:0] ST_NUM_W  = 5'd18;
    localparam logic [4:0] ST_SH     = 5'd19;
    localparam logic [4:0] ST_SH_W   = 5'd20;
    localparam logic [4:0] ST_OUT    = 5'd21;

    logic [4:0]   state_reg, state_next;

    // config registers
    logic [47:0]  capital_reg, capital_next;
    logic [31:0]  factor_reg, factor_next;

    // curve state
    logic [47:0]  cur_reg, cur_next;
    logic         last_reg, last_next;
    logic [47:0]  peak_reg, peak_next;
    logic [47:0]  prev_reg, prev_next;
    logic         havep_reg, havep_next;
    logic [24:0]  worst_reg, worst_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [63:0]  sum_reg, sum_next;      // signed, Q.24
    logic [63:0]  sqs_reg, sqs_next;      // unsigned, Q.48

    // scratch
    logic [31:0]  r_reg, r_next;
    logic [31:0]  total_reg, total_next;
    logic [127:0] wide_reg, wide_next;    // n*Q, then n*Q - S*S, then |S|*factor
    logic [63:0]  dev_reg, dev_next;
    logic [31:0]  sh_reg, sh_next;
    logic         shv_reg, shv_next;

    // result word
    logic         ov_reg, ov_next;
    logic [31:0]  o_total_reg, o_total_next;
    logic [24:0]  o_dd_reg, o_dd_next;
    logic [31:0]  o_sh_reg, o_sh_next;
    logic         o_shv_reg, o_shv_next;

    // shared units
    logic         div_start, div_done;
    div_req_t     div_req;
    logic [63:0]  div_q;
    logic         mul_start, mul_done;
    logic [63:0]  mul_a, mul_b;
    logic [127:0] mul_p;
    logic         sqrt_start, sqrt_done;
    logic [63:0]  sqrt_root;

    logic [63:0]  mag_r, mag_s;
    logic [63:0]  r_ext;
    logic [64:0]  sum_add, sqs_add;
    logic [63:0]  ratio_off;
    logic [47:0]  base;
    logic         ret_ok;

    assign r_ext   = {{32{r_reg[31]}}, r_reg};
    assign mag_r   = r_reg[31] ? 64'(~r_ext + 64'd1) : r_ext;
    assign mag_s   = sum_reg[63] ? (~sum_reg + 64'd1) : sum_reg;
    assign sum_add = {sum_reg[63], sum_reg} + {r_ext[63], r_ext};
    assign sqs_add = {1'b0, sqs_reg} + {1'b0, mul_p[63:0]};
    assign ratio_off = div_q - ONE_Q24;
    assign base    = (capital_reg == '0) ? 48'd1 : capital_reg;
    assign ret_ok  = havep_reg && (prev_reg != '0) && (cnt_reg < CNT_LIMIT);

    ecrm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .req   (div_req),
        .done  (div_done),
        .quot  (div_q)
    );

    ecrm_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_p)
    );

    ecrm_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (wide_reg),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    always_comb
    begin
        state_next   = state_reg;
        capital_next = capital_reg;
        factor_next  = factor_reg;
        cur_next     = cur_reg;
        last_next    = last_reg;
        peak_next    = peak_reg;
        prev_next    = prev_reg;
        havep_next   = havep_reg;
        worst_next   = worst_reg;
        cnt_next     = cnt_reg;
        sum_next     = sum_reg;
        sqs_next     = sqs_reg;
        r_next       = r_reg;
        total_next   = total_reg;
        wide_next    = wide_reg;
        dev_next     = dev_reg;
        sh_next      = sh_reg;
        shv_next     = shv_reg;
        ov_next      = ov_reg & out_stall;
        o_total_next = o_total_reg;
        o_dd_next    = o_dd_reg;
        o_sh_next    = o_sh_reg;
        o_shv_next   = o_shv_reg;
        div_start    = 1'b0;
        div_req      = '0;
        mul_start    = 1'b0;
        mul_a        = '0;
        mul_b        = '0;
        sqrt_start   = 1'b0;

        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_CAPITAL: capital_next = cfg_data;
                CFG_FACTOR:  factor_next  = cfg_data[31:0];
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cur_next   = equity_value;
                    last_next  = last_sample;
                    state_next = ST_PEAK;
                end
            end
            ST_PEAK:
            begin
                if (cur_reg > peak_reg)
                    peak_next = cur_reg;
                state_next = ST_DD;
            end
            ST_DD:
            begin
                if (peak_reg != '0)
                begin
                    div_start   = 1'b1;
                    div_req.num = {peak_reg - cur_reg, 80'd0};
                    div_req.den = {16'd0, peak_reg};
                    div_req.iters = FRAC_ITERS;
                    div_req.cap = ONE_Q24;
                    state_next  = ST_DD_W;
                end
                else
                    state_next = ST_RET;
            end
            ST_DD_W:
            begin
                if (div_done)
                begin
                    if (div_q[24:0] > worst_reg)
                        worst_next = div_q[24:0];
                    state_next = ST_RET;
                end
            end
            ST_RET:
            begin
                if (ret_ok)
                begin
                    div_start   = 1'b1;
                    div_req.num = {cur_reg, 80'd0};
                    div_req.den = {16'd0, prev_reg};
                    div_req.iters = FRAC_ITERS;
                    div_req.cap = RATIO_CAP;
                    state_next  = ST_RET_W;
                end
                else
                    state_next = ST_ADV;
            end
            ST_RET_W:
            begin
                if (div_done)
                begin
                    r_next     = ratio_off[31:0];
                    state_next = ST_SQ;
                end
            end
            ST_SQ:
            begin
                mul_start  = 1'b1;
                mul_a      = mag_r;
                mul_b      = mag_r;
                state_next = ST_SQ_W;
            end
            ST_SQ_W:
            begin
                if (mul_done)
                begin
                    // only a positive return can overflow the signed sum
                    if (!r_reg[31] && sum_add[64:63] == 2'b01)
                        sum_next = 64'h7FFF_FFFF_FFFF_FFFF;
                    else
                        sum_next = sum_add[63:0];
                    sqs_next   = sqs_add[64] ? '1 : sqs_add[63:0];
                    cnt_next   = cnt_reg + CW'(1);
                    state_next = ST_ADV;
                end
            end
            ST_ADV:
            begin
                prev_next  = cur_reg;
                havep_next = 1'b1;
                state_next = last_reg ? ST_TOT : ST_IDLE;
            end
            ST_TOT:
            begin
                div_start   = 1'b1;
                div_req.num = {cur_reg, 80'd0};
                div_req.den = {16'd0, base};
                div_req.iters = FRAC_ITERS;
                div_req.cap = RATIO_CAP;
                state_next  = ST_TOT_W;
            end
            ST_TOT_W:
            begin
                if (div_done)
                begin
                    total_next = ratio_off[31:0];
                    sh_next    = '0;
                    shv_next   = 1'b0;
                    state_next = (cnt_reg >= CW'(2)) ? ST_NQ : ST_OUT;
                end
            end
            ST_NQ:
            begin
                mul_start  = 1'b1;
                mul_a      = 64'(cnt_reg);
                mul_b      = sqs_reg;
                state_next = ST_NQ_W;
            end
            ST_NQ_W:
            begin
                if (mul_done)
                begin
                    wide_next  = mul_p;
                    state_next = ST_S2;
                end
            end
            ST_S2:
            begin
                mul_start  = 1'b1;
                mul_a      = mag_s;
                mul_b      = mag_s;
                state_next = ST_S2_W;
            end
            ST_S2_W:
            begin
                if (mul_done)
                begin
                    if (wide_reg > mul_p)
                    begin
                        wide_next  = wide_reg - mul_p;
                        state_next = ST_SQRT;
                    end
                    else
                        state_next = ST_OUT;
                end
            end
            ST_SQRT:
            begin
                sqrt_start = 1'b1;
                state_next = ST_SQRT_W;
            end
            ST_SQRT_W:
            begin
                if (sqrt_done)
                begin
                    dev_next   = sqrt_root;
                    state_next = (sqrt_root != '0) ? ST_NUM : ST_OUT;
                end
            end
            ST_NUM:
            begin
                mul_start  = 1'b1;
                mul_a      = mag_s;
                mul_b      = {32'd0, factor_reg};
                state_next = ST_NUM_W;
            end
            ST_NUM_W:
            begin
                if (mul_done)
                begin
                    wide_next  = mul_p;
                    state_next = ST_SH;
                end
            end
            ST_SH:
            begin
                div_start   = 1'b1;
                div_req.num = wide_reg;
                div_req.den = dev_reg;
                div_req.iters = WIDE_ITERS;
                div_req.cap = sum_reg[63] ? NEG_CAP : POS_CAP;
                state_next  = ST_SH_W;
            end
            ST_SH_W:
            begin
                if (div_done)
                begin
                    sh_next    = sum_reg[63] ? 32'(~div_q[31:0] + 32'd1) : div_q[31:0];
                    shv_next   = 1'b1;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                // wait for the result register to free up
                if (!ov_reg || !out_stall)
                begin
                    ov_next      = 1'b1;
                    o_total_next = total_reg;
                    o_dd_next    = worst_reg;
                    o_sh_next    = sh_reg;
                    o_shv_next   = shv_reg;
                    peak_next    = '0;
                    prev_next    = '0;
                    havep_next   = 1'b0;
                    worst_next   = '0;
                    cnt_next     = '0;
                    sum_next     = '0;
                    sqs_next     = '0;
                    state_next   = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            capital_reg <= CAPITAL_RESET;
            factor_reg  <= FACTOR_RESET;
            peak_reg    <= '0;
            prev_reg    <= '0;
            havep_reg   <= 1'b0;
            worst_reg   <= '0;
            cnt_reg     <= '0;
            sum_reg     <= '0;
            sqs_reg     <= '0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            capital_reg <= capital_next;
            factor_reg  <= factor_next;
            peak_reg    <= peak_next;
            prev_reg    <= prev_next;
            havep_reg   <= havep_next;
            worst_reg   <= worst_next;
            cnt_reg     <= cnt_next;
            sum_reg     <= sum_next;
            sqs_reg     <= sqs_next;
            ov_reg      <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg     <= cur_next;
        last_reg    <= last_next;
        r_reg       <= r_next;
        total_reg   <= total_next;
        wide_reg    <= wide_next;
        dev_reg     <= dev_next;
        sh_reg      <= sh_next;
        shv_reg     <= shv_next;
        o_total_reg <= o_total_next;
        o_dd_reg    <= o_dd_next;
        o_sh_reg    <= o_sh_next;
        o_shv_reg   <= o_shv_next;
    end

    assign in_stall         = (state_reg != ST_IDLE);
    assign out_valid        = ov_reg;
    assign total_ret        = o_total_reg;
    assign largest_drawdown = o_dd_reg;
    assign sharpe           = o_sh_reg;
    assign sharpe_valid     = o_shv_reg;

endmodule
